FILE: rtl/core/cld_pkg.sv
package cld_pkg;

  // register index width and register map
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_LOC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LOC       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SCALE     = 2'd3;

  // multiplier partial-product chunk
  localparam int MUL_CHUNK = 16;

endpackage

FILE: rtl/core/cld_dly.sv
module cld_dly #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < D; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[D-1];
endmodule

FILE: rtl/core/cld_mul.sv
module cld_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  import cld_pkg::*;

  localparam int CW = MUL_CHUNK;
  localparam int NC = (BW + CW - 1) / CW;
  localparam int SW = AW + NC * CW;

  logic [NC*CW-1:0] bx;
  logic [AW+CW-1:0] pp [NC];
  logic [SW-1:0]    acc;

  assign bx = (NC*CW)'(b);

  // stage 1: one partial product per chunk of b
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        pp[i] <= (AW+CW)'(a) * (AW+CW)'(bx[i*CW +: CW]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NC; i++) begin
      acc = acc + (SW'(pp[i]) << (i * CW));
    end
  end

  // stage 2: partial-product sum
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (AW+BW)'(acc);
    end
  end
endmodule

FILE: rtl/core/cld_div.sv
module cld_div #(
  parameter int NW  = 64,
  parameter int DDW = 32,
  parameter int QW  = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [DDW-1:0] den,
  input  logic           neg,
  output logic [QW-1:0]  q,
  output logic           clip
);
  localparam int WW = ((NW > DDW + QW) ? NW : DDW + QW) + 2;

  logic [WW-1:0]  rem [QW+1];
  logic [DDW-1:0] dv  [QW+1];
  logic [QW-1:0]  qb  [QW+1];
  logic           ng  [QW+1];
  logic           hg  [QW+1];
  logic [QW:0]    qr;
  logic [QW:0]    half;

  // stage 0: load, flag quotients that overflow QW bits
  // then one quotient bit per stage, msb first
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= WW'(num);
      dv[0]  <= den;
      qb[0]  <= '0;
      ng[0]  <= neg;
      hg[0]  <= WW'(num) >= (WW'(den) << QW);
      for (int i = 0; i < QW; i++) begin
        if (rem[i] >= (WW'(dv[i]) << (QW - 1 - i))) begin
          rem[i+1] <= rem[i] - (WW'(dv[i]) << (QW - 1 - i));
          qb[i+1]  <= qb[i] | (QW'(1) << (QW - 1 - i));
        end else begin
          rem[i+1] <= rem[i];
          qb[i+1]  <= qb[i];
        end
        dv[i+1] <= dv[i];
        ng[i+1] <= ng[i];
        hg[i+1] <= hg[i];
      end
    end
  end

  // round half away from zero on the magnitude
  assign qr   = {1'b0, qb[QW]} + (QW+1)'(((rem[QW] << 1) >= WW'(dv[QW])) ? 1'b1 : 1'b0);
  assign half = (QW+1)'(1) << (QW - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ng[QW]) begin
        if (hg[QW] || qr > half) begin
          q    <= QW'(half);
          clip <= 1'b1;
        end else begin
          q    <= QW'((QW+1)'(0) - qr);
          clip <= 1'b0;
        end
      end else begin
        if (hg[QW] || qr > half - (QW+1)'(1)) begin
          q    <= QW'(half - (QW+1)'(1));
          clip <= 1'b1;
        end else begin
          q    <= QW'(qr);
          clip <= 1'b0;
        end
      end
    end
  end
endmodule

FILE: rtl/core/cauchy_loglik_derivatives.sv
// Throughput: one transaction per cycle; the whole pipe advances together and
// halts only while the output register holds a result the sink has not taken.
// Latency is set by the restoring dividers, one quotient bit per stage.
// Reset (rst, synchronous): clears all valid bits and the registers to
// broadcast off, fixed_loc 0, fixed_scale 1.0.
module cauchy_loglik_derivatives #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  // lsb up: obs, loc, scale, zero pad
  input  logic [((3*DATA_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // lsb up: grad_loc, grad_scale, hess_loc_loc, hess_scale_scale, hess_loc_scale, pad
  output logic [((5*DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // bit 0: clipped
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we,
  input  logic [cld_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [DATA_WIDTH-1:0]               cfg_data
);
  import cld_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int OW  = ((5*DW+7)/8)*8;
  localparam int LAT = DW + 11;

  // pipeline enable: everything moves unless the output is stuck
  logic en;
  logic vld [1:LAT];

  assign en            = !vld[LAT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_axis_tvalid;
      for (int i = 2; i <= LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // configuration registers
  logic          broadcast_loc;
  logic [DW-1:0] fixed_loc;
  logic          broadcast_scale;
  logic [DW-2:0] fixed_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      broadcast_loc   <= 1'b0;
      fixed_loc       <= '0;
      broadcast_scale <= 1'b0;
      fixed_scale     <= (DW-1)'(1) << F;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BROADCAST_LOC:   broadcast_loc   <= cfg_data[0];
        CFG_FIXED_LOC:       fixed_loc       <= cfg_data;
        CFG_BROADCAST_SCALE: broadcast_scale <= cfg_data[0];
        CFG_FIXED_SCALE:     fixed_scale     <= cfg_data[DW-2:0];
        default: ;
      endcase
    end
  end

  // ---- c1: operand select, residual magnitude, zero scale forced to one LSB
  logic [DW-1:0] obs_i, loc_i, m_sel;
  logic [DW-2:0] s_sel, s_fix;
  logic [DW:0]   r_c;
  logic [DW:0]   a1;
  logic          rneg1;
  logic [DW-2:0] s1;

  assign obs_i = s_axis_tdata[DW-1:0];
  assign loc_i = s_axis_tdata[2*DW-1:DW];
  assign m_sel = broadcast_loc ? fixed_loc : loc_i;
  assign s_sel = broadcast_scale ? fixed_scale : s_axis_tdata[3*DW-2:2*DW];
  assign s_fix = (s_sel == '0) ? (DW-1)'(1) : s_sel;
  assign r_c   = {obs_i[DW-1], obs_i} - {m_sel[DW-1], m_sel};

  always_ff @(posedge clk) begin
    if (en) begin
      rneg1 <= r_c[DW];
      a1    <= r_c[DW] ? ((DW+1)'(0) - r_c) : r_c;
      s1    <= s_fix;
    end
  end

  // ---- c1 -> c3: squares and cross product
  logic [2*DW+1:0] r2_3;
  logic [2*DW-3:0] s2_3;
  logic [2*DW-1:0] sr_3;

  cld_mul #(.AW(DW+1), .BW(DW+1)) u_mul_r2 (.clk, .en, .a(a1), .b(a1), .p(r2_3));
  cld_mul #(.AW(DW-1), .BW(DW-1)) u_mul_s2 (.clk, .en, .a(s1), .b(s1), .p(s2_3));
  cld_mul #(.AW(DW-1), .BW(DW+1)) u_mul_sr (.clk, .en, .a(s1), .b(a1), .p(sr_3));

  // ---- c4: den = r^2 + s^2, |r^2 - s^2|
  logic [2*DW+2:0] den4;
  logic [2*DW+1:0] dmag4;
  logic            dneg4;
  logic [2*DW-3:0] s2_4;
  logic [2*DW+1:0] r2_4;
  logic [DW-2:0]   s4;

  always_ff @(posedge clk) begin
    if (en) begin
      den4  <= (2*DW+3)'(r2_3) + (2*DW+3)'(s2_3);
      dneg4 <= r2_3 < (2*DW+2)'(s2_3);
      dmag4 <= (r2_3 < (2*DW+2)'(s2_3)) ? ((2*DW+2)'(s2_3) - r2_3)
                                          : (r2_3 - (2*DW+2)'(s2_3));
    end
  end

  cld_dly #(.W(2*DW-2), .D(1)) u_d_s2_4 (.clk, .en, .d(s2_3), .q(s2_4));
  cld_dly #(.W(2*DW+2), .D(1)) u_d_r2_4 (.clk, .en, .d(r2_3), .q(r2_4));
  cld_dly #(.W(DW-1),   .D(3)) u_d_s4   (.clk, .en, .d(s1),   .q(s4));

  // ---- c4 -> c6: second-order products
  logic [4*DW+5:0] den2_6;
  logic [3*DW+1:0] sden_6;
  logic [4*DW-5:0] pos_6;
  logic [4*DW-1:0] s2r2_6;
  logic [4*DW+3:0] r2r2_6;

  cld_mul #(.AW(2*DW+3), .BW(2*DW+3)) u_mul_den2 (.clk, .en, .a(den4), .b(den4), .p(den2_6));
  cld_mul #(.AW(DW-1),   .BW(2*DW+3)) u_mul_sden (.clk, .en, .a(s4),   .b(den4), .p(sden_6));
  cld_mul #(.AW(2*DW-2), .BW(2*DW-2)) u_mul_s4p  (.clk, .en, .a(s2_4), .b(s2_4), .p(pos_6));
  cld_mul #(.AW(2*DW-2), .BW(2*DW+2)) u_mul_s2r2 (.clk, .en, .a(s2_4), .b(r2_4), .p(s2r2_6));
  cld_mul #(.AW(2*DW+2), .BW(2*DW+2)) u_mul_r4   (.clk, .en, .a(r2_4), .b(r2_4), .p(r2r2_6));

  // ---- c7/c8: scale-scale numerator s^4 - 4 s^2 r^2 - r^4, sign and magnitude
  logic [4*DW+6:0] negp7, hmag8;
  logic [4*DW-5:0] pos7;
  logic            hneg8;

  always_ff @(posedge clk) begin
    if (en) begin
      negp7 <= ((4*DW+7)'(s2r2_6) << 2) + (4*DW+7)'(r2r2_6);
      pos7  <= pos_6;
      hneg8 <= (4*DW+7)'(pos7) < negp7;
      hmag8 <= ((4*DW+7)'(pos7) < negp7) ? (negp7 - (4*DW+7)'(pos7))
                                           : ((4*DW+7)'(pos7) - negp7);
    end
  end

  // ---- c6 -> c8: s^2 * den^2 for the scale-scale divisor
  logic [2*DW-3:0] s2_6;
  logic [6*DW+3:0] d3_8;

  cld_dly #(.W(2*DW-2), .D(2)) u_d_s2_6 (.clk, .en, .d(s2_4), .q(s2_6));
  cld_mul #(.AW(2*DW-2), .BW(4*DW+6)) u_mul_d3 (.clk, .en, .a(s2_6), .b(den2_6), .p(d3_8));

  // ---- align divider operands at c8
  logic [DW:0]     a8;
  logic            rneg8;
  logic [2*DW-1:0] sr8;
  logic [2*DW+2:0] den8;
  logic [2*DW+1:0] dmag8;
  logic            dneg8;
  logic [4*DW+5:0] den2_8;
  logic [3*DW+1:0] sden8;

  cld_dly #(.W(DW+1),   .D(7)) u_d_a8    (.clk, .en, .d(a1),     .q(a8));
  cld_dly #(.W(1),      .D(7)) u_d_rneg8 (.clk, .en, .d(rneg1),  .q(rneg8));
  cld_dly #(.W(2*DW),   .D(5)) u_d_sr8   (.clk, .en, .d(sr_3),   .q(sr8));
  cld_dly #(.W(2*DW+3), .D(4)) u_d_den8  (.clk, .en, .d(den4),   .q(den8));
  cld_dly #(.W(2*DW+2), .D(4)) u_d_dmag8 (.clk, .en, .d(dmag4),  .q(dmag8));
  cld_dly #(.W(1),      .D(4)) u_d_dneg8 (.clk, .en, .d(dneg4),  .q(dneg8));
  cld_dly #(.W(4*DW+6), .D(2)) u_d_den28 (.clk, .en, .d(den2_6), .q(den2_8));
  cld_dly #(.W(3*DW+2), .D(2)) u_d_sden8 (.clk, .en, .d(sden_6), .q(sden8));

  // ---- c8 -> c(DW+10): five rounded, saturating dividers
  logic [DW-1:0] q0, q1, q2, q3, q4;
  logic          c0, c1, c2, c3, c4;

  // grad_loc = 2r / den
  cld_div #(.NW(DW+2*F+2), .DDW(2*DW+3), .QW(DW)) u_div_gl (
    .clk, .en, .num((DW+2*F+2)'(a8) << (2*F+1)), .den(den8), .neg(rneg8),
    .q(q0), .clip(c0));

  // grad_scale = (r^2 - s^2) / (s * den)
  cld_div #(.NW(2*DW+2+2*F), .DDW(3*DW+2), .QW(DW)) u_div_gs (
    .clk, .en, .num((2*DW+2+2*F)'(dmag8) << (2*F)), .den(sden8), .neg(dneg8),
    .q(q1), .clip(c1));

  // hess_loc_loc = 2(r^2 - s^2) / den^2
  cld_div #(.NW(2*DW+3+3*F), .DDW(4*DW+6), .QW(DW)) u_div_hll (
    .clk, .en, .num((2*DW+3+3*F)'(dmag8) << (3*F+1)), .den(den2_8), .neg(dneg8),
    .q(q2), .clip(c2));

  // hess_scale_scale = (s^4 - 4s^2r^2 - r^4) / (s^2 * den^2)
  cld_div #(.NW(4*DW+7+3*F), .DDW(6*DW+4), .QW(DW)) u_div_hss (
    .clk, .en, .num((4*DW+7+3*F)'(hmag8) << (3*F)), .den(d3_8), .neg(hneg8),
    .q(q3), .clip(c3));

  // hess_loc_scale = -4sr / den^2
  cld_div #(.NW(2*DW+3*F+2), .DDW(4*DW+6), .QW(DW)) u_div_hls (
    .clk, .en, .num((2*DW+3*F+2)'(sr8) << (3*F+2)), .den(den2_8), .neg(!rneg8),
    .q(q4), .clip(c4));

  // ---- output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata    <= OW'({q4, q3, q2, q1, q0});
      m_axis_tuser[0] <= c0 | c1 | c2 | c3 | c4;
    end
  end
endmodule

FILE: dv/tb.sv
module tb;
  import cld_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IN_W  = ((3*DATA_WIDTH-1+7)/8)*8;
  localparam int OUT_W = ((5*DATA_WIDTH+7)/8)*8;
  localparam int WIDE  = 320;            // room for s^2 * den^2 and the shifted numerators
  localparam int LATENCY = DATA_WIDTH + 11;
  localparam int IDLE_LIMIT = 4000;      // cycles with no transaction before giving up

  typedef logic [WIDE-1:0] wide_t;

  typedef struct {
    logic [OUT_W-1:0] grads;             // five Q16.16 results, grad_loc lowest
    logic             clipped;
  } deriv_t;

  logic clk, rst;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             s_axis_tvalid, s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0]       m_axis_tuser;
  logic             m_axis_tvalid, m_axis_tready;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [DATA_WIDTH-1:0] cfg_data;

  cauchy_loglik_derivatives #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) dut (.*);

  // predictor copy of the register file
  logic                  bc_loc, bc_scale;
  logic [DATA_WIDTH-1:0] shared_loc;
  logic [DATA_WIDTH-2:0] shared_scale;

  deriv_t expected_derivs[$];
  int errors, items_sent, results_seen, clipped_seen, idle_cycles;
  int burst_left, gap_len;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  // Rounded (ties away from zero), saturated quotient of +/-num/den.
  // Returns {clip, code}.
  function automatic logic [DATA_WIDTH:0] round_div(wide_t num, bit neg, wide_t den);
    wide_t q, rem;
    logic [DATA_WIDTH-1:0] half;
    bit huge;
    half = 1 << (DATA_WIDTH - 1);
    huge = num >= (den << DATA_WIDTH);
    q = 0;
    if (!huge) begin
      q = num / den;
      rem = num % den;
      if ((rem << 1) >= den) q = q + 1;
    end
    if (neg) begin
      if (huge || q > half) return {1'b1, half};
      return {1'b0, DATA_WIDTH'(-q)};
    end
    if (huge || q > half - 1) return {1'b1, half - 1'b1};
    return {1'b0, q[DATA_WIDTH-1:0]};
  endfunction

  function automatic deriv_t cauchy_derivs(logic [DATA_WIDTH-1:0] obs,
                                           logic [DATA_WIDTH-1:0] loc_in,
                                           logic [DATA_WIDTH-2:0] scale_in);
    logic signed [DATA_WIDTH:0] resid;
    logic [DATA_WIDTH-2:0] s;
    wide_t ra, sw, r2, s2, den, den2, dmag, pos, negp, hmag;
    bit rneg, dneg, hneg;
    logic [DATA_WIDTH:0] q[5];
    deriv_t d;
    resid = $signed({obs[DATA_WIDTH-1], obs})
          - (bc_loc ? $signed({shared_loc[DATA_WIDTH-1], shared_loc})
                    : $signed({loc_in[DATA_WIDTH-1], loc_in}));
    s = bc_scale ? shared_scale : scale_in;
    if (s == 0) s = 1;                    // zero scale counts as one LSB
    rneg = resid < 0;
    ra = rneg ? wide_t'(-resid) : wide_t'(resid);
    ra = ra & ((wide_t'(1) << (DATA_WIDTH + 1)) - 1);
    sw = wide_t'(s);
    r2 = ra * ra;
    s2 = sw * sw;
    den = r2 + s2;
    den2 = den * den;
    dneg = r2 < s2;
    dmag = dneg ? s2 - r2 : r2 - s2;
    pos = s2 * s2;
    negp = ((s2 * r2) << 2) + r2 * r2;
    hneg = pos < negp;
    hmag = hneg ? negp - pos : pos - negp;
    q[0] = round_div(ra << (2*FRAC_BITS + 1), rneg, den);
    q[1] = round_div(dmag << (2*FRAC_BITS), dneg, sw * den);
    q[2] = round_div(dmag << (3*FRAC_BITS + 1), dneg, den2);
    q[3] = round_div(hmag << (3*FRAC_BITS), hneg, s2 * den2);
    q[4] = round_div((sw * ra) << (3*FRAC_BITS + 2), !rneg, den2);
    d.grads = '0;
    d.clipped = 0;
    for (int i = 0; i < 5; i++) begin
      d.grads[i*DATA_WIDTH +: DATA_WIDTH] = q[i][DATA_WIDTH-1:0];
      d.clipped |= q[i][DATA_WIDTH];
    end
    return d;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
                                 logic [DATA_WIDTH-1:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, results_seen);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      deriv_t e;
      if (expected_derivs.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata[DATA_WIDTH-1:0], '0);
      end else begin
        e = expected_derivs.pop_front();
        if (m_axis_tdata[0 +: DATA_WIDTH] !== e.grads[0 +: DATA_WIDTH])
          report_mismatch("grad_loc", m_axis_tdata[0 +: DATA_WIDTH], e.grads[0 +: DATA_WIDTH]);
        if (m_axis_tdata[32 +: 32] !== e.grads[32 +: 32])
          report_mismatch("grad_scale", m_axis_tdata[32 +: 32], e.grads[32 +: 32]);
        if (m_axis_tdata[64 +: 32] !== e.grads[64 +: 32])
          report_mismatch("hess_loc_loc", m_axis_tdata[64 +: 32], e.grads[64 +: 32]);
        if (m_axis_tdata[96 +: 32] !== e.grads[96 +: 32])
          report_mismatch("hess_scale_scale", m_axis_tdata[96 +: 32], e.grads[96 +: 32]);
        if (m_axis_tdata[128 +: 32] !== e.grads[128 +: 32])
          report_mismatch("hess_loc_scale", m_axis_tdata[128 +: 32], e.grads[128 +: 32]);
        if (m_axis_tuser[0] !== e.clipped)
          report_mismatch("clipped", m_axis_tuser[0], e.clipped);
        clipped_seen += e.clipped;
      end
      results_seen++;
    end
  end

  // watchdog: any stretch with no transaction on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  // sink stall pattern: switches between always-ready, light and heavy stalls
  int stall_mode, mode_left;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // ---------------------------------------------------------------- drivers
  // Sends one observation; bursts with random gaps between them.
  task automatic send_obs(logic [31:0] obs, logic [31:0] loc, logic [30:0] scale);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tdata  <= {1'b0, scale, loc, obs};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_derivs.push_back(cauchy_derivs(obs, loc, scale));
    items_sent++;
    @(negedge clk);
  endtask

  // Drain the pipe, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_WIDTH-1:0] value);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (expected_derivs.size() == 0);
    repeat (LATENCY + 5) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BROADCAST_LOC:   bc_loc = value[0];
      CFG_FIXED_LOC:       shared_loc = value;
      CFG_BROADCAST_SCALE: bc_scale = value[0];
      CFG_FIXED_SCALE:     shared_scale = value[DATA_WIDTH-2:0];
      default: ;
    endcase
  endtask

  // Mix of full-range codes, values near the scale, and extremes.
  function automatic logic [31:0] pick_value(int shape);
    case (shape)
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      default: case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0;
        default: return 32'hffff_ffff;
      endcase
    endcase
  endfunction

  function automatic logic [30:0] pick_scale(int shape);
    case (shape)
      0: return 31'($urandom);
      1: return 31'($urandom_range(1, 1 << 19));
      default: case ($urandom_range(0, 3))
        0: return 31'd1;
        1: return 31'h7fff_ffff;
        2: return 31'd0;
        default: return 31'h1_0000;
      endcase
    endcase
  endfunction

  task automatic send_random(int count);
    int shape;
    for (int i = 0; i < count; i++) begin
      shape = $urandom_range(0, 9);
      // mostly residuals on the order of the scale, where results are in range
      if (shape < 6)
        send_obs(pick_value(1), pick_value(1), pick_scale(1));
      else if (shape < 9)
        send_obs(pick_value(0), pick_value(0), pick_scale(0));
      else
        send_obs(pick_value(2), pick_value($urandom_range(0, 2)), pick_scale(2));
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_obs(32'h0001_0000, 32'h0, 31'h1_0000);        // r = s
    send_obs(32'h0, 32'h0001_0000, 31'h1_0000);        // r = -s
    send_obs(32'h0, 32'h0, 31'h1_0000);                // zero residual
    send_obs(32'h0002_0000, 32'h0, 31'h1_0000);
    send_obs(32'h0, 32'h0, 31'd0);                     // zero scale
    send_obs(32'h0000_0001, 32'h0, 31'd0);
    send_obs(32'h0, 32'h0, 31'd1);                     // tiny scale: saturates
    send_obs(32'h7fff_ffff, 32'h8000_0000, 31'd1);     // largest residual
    send_obs(32'h8000_0000, 32'h7fff_ffff, 31'd1);     // most negative residual
    send_obs(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_obs(32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
    send_obs(32'h0, 32'h0, 31'h7fff_ffff);             // largest scale
    send_obs(32'hffff_ffff, 32'h0, 31'd1);
    send_obs(32'h0000_8000, 32'h0, 31'h1_0000);        // half unit residual
    send_obs(32'hffff_8000, 32'h0, 31'h0_8000);
    send_obs(32'h0000_0003, 32'h0, 31'd1);
    send_obs(32'h5555_5555, 32'haaaa_aaaa, 31'h2aaa_aaaa);
    send_obs(32'haaaa_aaaa, 32'h5555_5555, 31'h5555_5555);
  endtask

  task automatic test_broadcast_loc();
    write_reg(CFG_FIXED_LOC, 32'h8000_0000);
    write_reg(CFG_BROADCAST_LOC, 1);
    send_random(100);
    write_reg(CFG_FIXED_LOC, 32'h7fff_ffff);
    send_random(60);
    write_reg(CFG_FIXED_LOC, pick_value(1));
    send_random(140);
    write_reg(CFG_BROADCAST_LOC, 0);
  endtask

  task automatic test_broadcast_scale();
    write_reg(CFG_BROADCAST_SCALE, 1);
    send_random(80);                                   // reset scale of 1.0
    write_reg(CFG_FIXED_SCALE, 0);                     // zero shared scale
    send_random(50);
    write_reg(CFG_FIXED_SCALE, 32'h7fff_ffff);
    send_random(50);
    write_reg(CFG_FIXED_SCALE, pick_scale(1));
    send_random(120);
  endtask

  task automatic test_both_shared();
    write_reg(CFG_FIXED_LOC, pick_value(1));
    write_reg(CFG_BROADCAST_LOC, 1);
    send_random(150);
    write_reg(CFG_BROADCAST_LOC, 0);
    write_reg(CFG_BROADCAST_SCALE, 0);
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_data = '0;
    bc_loc = 0;
    bc_scale = 0;
    shared_loc = '0;
    shared_scale = 1 << FRAC_BITS;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    clipped_seen = 0;
    idle_cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    mode_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    test_directed();
    send_random(832);
    test_broadcast_loc();
    test_broadcast_scale();
    test_both_shared();
    send_random(200);

    s_axis_tvalid <= 1'b0;
    wait (expected_derivs.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d observations, %0d results checked, %0d saturated",
             items_sent, results_seen, clipped_seen);
    $display("register settings: default, shared location, shared scale, both, extremes");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
